// ===== sv/tapa_pkg.sv =====
package tapa_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int SIDE_W    = 32;
    localparam int PERIM_W   = 34;
    localparam int AREA_W    = 47;
    localparam int ANGLE_W   = 24;

    // limb multiplier: 3 x 3 limbs of 32 bits, one partial product per stage
    localparam int LIMB_W    = 32;
    localparam int MUL_LIMBS = 3;
    localparam int MUL_W     = LIMB_W * MUL_LIMBS;
    localparam int MUL_STEPS = MUL_LIMBS * MUL_LIMBS;

    // integer square root: two radicand bits per stage
    localparam int SQ_IN_W    = 128;
    localparam int SQ_OUT_W   = SQ_IN_W / 2;
    localparam int SQ_REM_W   = SQ_OUT_W + 2;
    localparam int SQRT_STEPS = SQ_OUT_W;

    // radicand windows taken from the 4-factor heron product
    localparam int H_SHIFT    = 4;
    localparam int AREA_SHIFT = 2 * FRAC_BITS + 4;

    // cordic
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
    localparam int XNUM_W       = 67;
    localparam int MAG_W        = 66;
    localparam int LEN_W        = 7;
    localparam int NORM_BITS    = 30;
    localparam int CW           = 34;
    localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
    localparam int ANG_HALF     = (1 << ANG_SH) >> 1;
    localparam logic signed [CW-1:0] DEG90  = CW'(64'd1509949440);
    localparam logic signed [CW-1:0] DEG180 = CW'(64'd3019898880);

    // pipeline bookkeeping, counted from the input register
    localparam int HEAD_LAT = 2 * MUL_STEPS + SQRT_STEPS;
    localparam int X_DLY    = HEAD_LAT - 2;
    localparam int META_DLY = HEAD_LAT + CORDIC_LAT;

    typedef struct packed {
        logic [SIDE_W-1:0] side_a;
        logic [SIDE_W-1:0] side_b;
        logic [SIDE_W-1:0] side_c;
    } t_in;

    typedef struct packed {
        logic               is_triangle;
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
        logic [ANGLE_W-1:0] angle_opp_a;
        logic [ANGLE_W-1:0] angle_opp_b;
        logic [ANGLE_W-1:0] angle_opp_c;
    } t_out;

    typedef struct packed {
        logic               is_triangle;
        logic [PERIM_W-1:0] perimeter;
    } t_meta;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [CW-1:0] atan_deg(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = CW'(754974720);
            1:  v = CW'(445687602);
            2:  v = CW'(235489088);
            3:  v = CW'(119537938);
            4:  v = CW'(60000934);
            5:  v = CW'(30029717);
            6:  v = CW'(15018523);
            7:  v = CW'(7509720);
            8:  v = CW'(3754917);
            9:  v = CW'(1877466);
            10: v = CW'(938734);
            11: v = CW'(469367);
            12: v = CW'(234684);
            13: v = CW'(117342);
            14: v = CW'(58671);
            15: v = CW'(29335);
            16: v = CW'(14668);
            17: v = CW'(7334);
            18: v = CW'(3667);
            19: v = CW'(1833);
            20: v = CW'(917);
            21: v = CW'(458);
            22: v = CW'(229);
            23: v = CW'(115);
            24: v = CW'(57);
            25: v = CW'(29);
            26: v = CW'(14);
            27: v = CW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/triangle_area_perimeter_angles_unit.sv =====
// triangle measurement unit
// input channel: i_in_valid / o_in_stall carry three unsigned side lengths
// (i_in_data); a transfer happens on a clock edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall carry the triangle check, the
// perimeter, the heron area and the three interior angles in degrees (o_out_data).
// when the sides fail the strict triangle inequality every result field is zero.
// the path from the input transfer to o_out_valid is the
// input register, two 9-stage limb multipliers for the heron product, a
// 64-stage square root and a 31-stage cordic with normalization and rounding.
// throughput: one triangle per cycle while no result is held, as the datapath is fully pipelined.
// reset (i_rst_n low, synchronous) clears all valid bits; data registers are
// not reset. while o_out_valid is high and i_out_stall is high, the whole
// pipeline holds and o_in_stall is raised, so nothing is lost or repeated;
// bubbles are carried along and never block an input transfer.
module triangle_area_perimeter_angles_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  tapa_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tapa_pkg::t_out   o_out_data
);

    logic                                   w_en;

    logic                                   r_v1;
    logic [tapa_pkg::SIDE_W-1:0]            r_a;
    logic [tapa_pkg::SIDE_W-1:0]            r_b;
    logic [tapa_pkg::SIDE_W-1:0]            r_c;
    tapa_pkg::t_meta                        r_meta1;
    logic [tapa_pkg::SIDE_W:0]              r_q;
    logic [tapa_pkg::SIDE_W:0]              r_r;
    logic [tapa_pkg::SIDE_W:0]              r_s;

    logic [tapa_pkg::SIDE_W:0]              w_ab;
    logic [tapa_pkg::SIDE_W:0]              w_bc;
    logic [tapa_pkg::SIDE_W:0]              w_ac;

    logic [2*tapa_pkg::SIDE_W-1:0]          r_sq_a;
    logic [2*tapa_pkg::SIDE_W-1:0]          r_sq_b;
    logic [2*tapa_pkg::SIDE_W-1:0]          r_sq_c;
    logic signed [tapa_pkg::XNUM_W-1:0]     r_xa_dly [tapa_pkg::X_DLY+1];
    logic signed [tapa_pkg::XNUM_W-1:0]     r_xb_dly [tapa_pkg::X_DLY+1];
    logic signed [tapa_pkg::XNUM_W-1:0]     r_xc_dly [tapa_pkg::X_DLY+1];

    logic [2*tapa_pkg::MUL_W-1:0]           w_pq;
    logic [2*tapa_pkg::MUL_W-1:0]           w_rs;
    logic [2*tapa_pkg::MUL_W-1:0]           w_prod;
    logic [tapa_pkg::SQ_OUT_W-1:0]          w_h;
    logic [tapa_pkg::SQ_OUT_W-1:0]          w_area_root;
    logic [tapa_pkg::AREA_W-1:0]            r_area_dly [tapa_pkg::CORDIC_LAT];
    logic [tapa_pkg::ANGLE_W-1:0]           w_ang_a;
    logic [tapa_pkg::ANGLE_W-1:0]           w_ang_b;
    logic [tapa_pkg::ANGLE_W-1:0]           w_ang_c;

    logic [tapa_pkg::META_DLY-1:0]          r_vld;
    tapa_pkg::t_meta                        r_meta_dly [tapa_pkg::META_DLY];
    tapa_pkg::t_meta                        w_meta_end;

    logic                                   r_out_valid;
    tapa_pkg::t_out                         r_out;
    tapa_pkg::t_out                         n_out;

    // the pipeline moves unless a finished result is held by the receiver
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // input register: triangle check and heron factors
    assign w_ab = {1'b0, i_in_data.side_a} + {1'b0, i_in_data.side_b};
    assign w_bc = {1'b0, i_in_data.side_b} + {1'b0, i_in_data.side_c};
    assign w_ac = {1'b0, i_in_data.side_a} + {1'b0, i_in_data.side_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= i_in_data.side_a;
            r_b <= i_in_data.side_b;
            r_c <= i_in_data.side_c;
            r_meta1.is_triangle <= ({1'b0, i_in_data.side_a} < w_bc)
                                && ({1'b0, i_in_data.side_b} < w_ac)
                                && ({1'b0, i_in_data.side_c} < w_ab);
            r_meta1.perimeter <= {1'b0, w_ab} + tapa_pkg::PERIM_W'(i_in_data.side_c);
            r_q <= w_bc - {1'b0, i_in_data.side_a};
            r_r <= w_ac - {1'b0, i_in_data.side_b};
            r_s <= w_ab - {1'b0, i_in_data.side_c};
        end
    end

    // side squares, then the law-of-cosines numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_a <= r_a * r_a;
            r_sq_b <= r_b * r_b;
            r_sq_c <= r_c * r_c;
            r_xa_dly[0] <= $signed(tapa_pkg::XNUM_W'(r_sq_b))
                         + $signed(tapa_pkg::XNUM_W'(r_sq_c))
                         - $signed(tapa_pkg::XNUM_W'(r_sq_a));
            r_xb_dly[0] <= $signed(tapa_pkg::XNUM_W'(r_sq_c))
                         + $signed(tapa_pkg::XNUM_W'(r_sq_a))
                         - $signed(tapa_pkg::XNUM_W'(r_sq_b));
            r_xc_dly[0] <= $signed(tapa_pkg::XNUM_W'(r_sq_a))
                         + $signed(tapa_pkg::XNUM_W'(r_sq_b))
                         - $signed(tapa_pkg::XNUM_W'(r_sq_c));
            for (int k = 1; k <= tapa_pkg::X_DLY; k++) begin
                r_xa_dly[k] <= r_xa_dly[k-1];
                r_xb_dly[k] <= r_xb_dly[k-1];
                r_xc_dly[k] <= r_xc_dly[k-1];
            end
        end
    end

    // heron product p*q*r*s
    tapa_mul u_mul_pq (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (tapa_pkg::MUL_W'(r_meta1.perimeter)),
        .i_b   (tapa_pkg::MUL_W'(r_q)),
        .o_p   (w_pq)
    );

    tapa_mul u_mul_rs (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (tapa_pkg::MUL_W'(r_r)),
        .i_b   (tapa_pkg::MUL_W'(r_s)),
        .o_p   (w_rs)
    );

    tapa_mul u_mul_prod (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_pq[tapa_pkg::MUL_W-1:0]),
        .i_b   (w_rs[tapa_pkg::MUL_W-1:0]),
        .o_p   (w_prod)
    );

    // the area with 32 fraction bits for the angles, and with 16 for the output
    tapa_sqrt u_sqrt_h (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (w_prod[tapa_pkg::H_SHIFT +: tapa_pkg::SQ_IN_W]),
        .o_root (w_h)
    );

    tapa_sqrt u_sqrt_area (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_n    (w_prod[tapa_pkg::AREA_SHIFT +: tapa_pkg::SQ_IN_W]),
        .o_root (w_area_root)
    );

    // one angle lane per side
    tapa_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x_num (r_xa_dly[tapa_pkg::X_DLY]),
        .i_h     (w_h),
        .o_angle (w_ang_a)
    );

    tapa_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x_num (r_xb_dly[tapa_pkg::X_DLY]),
        .i_h     (w_h),
        .o_angle (w_ang_b)
    );

    tapa_cordic u_cordic_c (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x_num (r_xc_dly[tapa_pkg::X_DLY]),
        .i_h     (w_h),
        .o_angle (w_ang_c)
    );

    // area waits for the angle lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_area_dly[0] <= w_area_root[tapa_pkg::AREA_W-1:0];
            for (int k = 1; k < tapa_pkg::CORDIC_LAT; k++) begin
                r_area_dly[k] <= r_area_dly[k-1];
            end
        end
    end

    // valid bits and per-item sideband travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[tapa_pkg::META_DLY-2:0], r_v1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_meta_dly[0] <= r_meta1;
            for (int k = 1; k < tapa_pkg::META_DLY; k++) begin
                r_meta_dly[k] <= r_meta_dly[k-1];
            end
        end
    end

    assign w_meta_end = r_meta_dly[tapa_pkg::META_DLY-1];

    // result assembly, zero when the sides do not form a triangle
    always_comb begin
        n_out = '0;
        if (w_meta_end.is_triangle) begin
            n_out.is_triangle = 1'b1;
            n_out.perimeter   = w_meta_end.perimeter;
            n_out.area        = r_area_dly[tapa_pkg::CORDIC_LAT-1];
            n_out.angle_opp_a = w_ang_a;
            n_out.angle_opp_b = w_ang_b;
            n_out.angle_opp_c = w_ang_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[tapa_pkg::META_DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a rejected triangle carries no measurements
    a_zero_when_not_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_triangle) |->
            (o_out_data.perimeter == '0 && o_out_data.area == '0 &&
             o_out_data.angle_opp_a == '0 && o_out_data.angle_opp_b == '0 &&
             o_out_data.angle_opp_c == '0))
        else $error("non-triangle result has nonzero fields");

    // angles never exceed 180 degrees
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.angle_opp_a <= tapa_pkg::ANGLE_W'(tapa_pkg::DEG180 >>> tapa_pkg::ANG_SH)
          && o_out_data.angle_opp_b <= tapa_pkg::ANGLE_W'(tapa_pkg::DEG180 >>> tapa_pkg::ANG_SH)
          && o_out_data.angle_opp_c <= tapa_pkg::ANGLE_W'(tapa_pkg::DEG180 >>> tapa_pkg::ANG_SH)))
        else $error("angle above 180 degrees");

    // input is only held back by a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // an input transfer enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted item lost at the input register");

    // a held pipeline keeps its valid bits
    a_hold_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(r_vld) && $stable(r_v1) && o_out_valid))
        else $error("valid bits changed while held");

endmodule

// ===== sv/tapa_mul.sv =====
module tapa_mul (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [tapa_pkg::MUL_W-1:0]      i_a,
    input  logic [tapa_pkg::MUL_W-1:0]      i_b,
    output logic [2*tapa_pkg::MUL_W-1:0]    o_p
);

    logic [tapa_pkg::MUL_W-1:0]   r_a   [tapa_pkg::MUL_STEPS];
    logic [tapa_pkg::MUL_W-1:0]   r_b   [tapa_pkg::MUL_STEPS];
    logic [2*tapa_pkg::MUL_W-1:0] r_acc [tapa_pkg::MUL_STEPS];

    // one 32x32 partial product added per stage
    for (genvar k = 0; k < tapa_pkg::MUL_STEPS; k++) begin : g_step
        localparam int AI = k / tapa_pkg::MUL_LIMBS;
        localparam int BJ = k % tapa_pkg::MUL_LIMBS;
        logic [tapa_pkg::MUL_W-1:0]    w_a;
        logic [tapa_pkg::MUL_W-1:0]    w_b;
        logic [2*tapa_pkg::MUL_W-1:0]  w_acc;
        logic [2*tapa_pkg::LIMB_W-1:0] w_pp;

        if (k == 0) begin : g_first
            assign w_a   = i_a;
            assign w_b   = i_b;
            assign w_acc = '0;
        end else begin : g_next
            assign w_a   = r_a[k-1];
            assign w_b   = r_b[k-1];
            assign w_acc = r_acc[k-1];
        end

        assign w_pp = w_a[AI*tapa_pkg::LIMB_W +: tapa_pkg::LIMB_W]
                    * w_b[BJ*tapa_pkg::LIMB_W +: tapa_pkg::LIMB_W];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= w_a;
                r_b[k]   <= w_b;
                r_acc[k] <= w_acc + ((2*tapa_pkg::MUL_W)'(w_pp)
                                     << (tapa_pkg::LIMB_W * (AI + BJ)));
            end
        end
    end

    assign o_p = r_acc[tapa_pkg::MUL_STEPS-1];

endmodule

// ===== sv/tapa_sqrt.sv =====
module tapa_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tapa_pkg::SQ_IN_W-1:0]  i_n,
    output logic [tapa_pkg::SQ_OUT_W-1:0] o_root
);

    logic [tapa_pkg::SQ_IN_W-1:0]  r_n    [tapa_pkg::SQRT_STEPS];
    logic [tapa_pkg::SQ_REM_W-1:0] r_rem  [tapa_pkg::SQRT_STEPS];
    logic [tapa_pkg::SQ_OUT_W-1:0] r_root [tapa_pkg::SQRT_STEPS];

    // restoring digit recurrence, one root bit per stage
    for (genvar s = 0; s < tapa_pkg::SQRT_STEPS; s++) begin : g_step
        logic [tapa_pkg::SQ_IN_W-1:0]    w_n;
        logic [tapa_pkg::SQ_REM_W-1:0]   w_rem;
        logic [tapa_pkg::SQ_OUT_W-1:0]   w_root;
        logic [tapa_pkg::SQ_REM_W+1:0]   w_cur;
        logic [tapa_pkg::SQ_REM_W+1:0]   w_trial;
        logic [tapa_pkg::SQ_REM_W+1:0]   w_diff;
        logic                            w_ge;

        if (s == 0) begin : g_first
            assign w_n    = i_n;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_n[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
        end

        assign w_cur   = {w_rem, w_n[tapa_pkg::SQ_IN_W-1 -: 2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_ge    = w_cur >= w_trial;
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s]    <= {w_n[tapa_pkg::SQ_IN_W-3:0], 2'b00};
                r_rem[s]  <= w_ge ? w_diff[tapa_pkg::SQ_REM_W-1:0]
                                  : w_cur[tapa_pkg::SQ_REM_W-1:0];
                r_root[s] <= {w_root[tapa_pkg::SQ_OUT_W-2:0], w_ge};
            end
        end
    end

    assign o_root = r_root[tapa_pkg::SQRT_STEPS-1];

endmodule

// ===== sv/tapa_cordic.sv =====
module tapa_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [tapa_pkg::XNUM_W-1:0]  i_x_num,
    input  logic [tapa_pkg::SQ_OUT_W-1:0]       i_h,
    output logic [tapa_pkg::ANGLE_W-1:0]        o_angle
);

    function automatic logic [tapa_pkg::LEN_W-1:0] bit_len(
        input logic [tapa_pkg::MAG_W-1:0] v
    );
        logic [tapa_pkg::LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < tapa_pkg::MAG_W; i++) begin
            if (v[i]) begin
                n = tapa_pkg::LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    logic                                r_neg;
    logic [tapa_pkg::MAG_W-1:0]          r_mag;
    logic [tapa_pkg::MAG_W-1:0]          r_yv;
    logic [tapa_pkg::LEN_W-1:0]          r_len;
    logic signed [tapa_pkg::CW-1:0]      r_x [tapa_pkg::CORDIC_STEPS+1];
    logic signed [tapa_pkg::CW-1:0]      r_y [tapa_pkg::CORDIC_STEPS+1];
    logic signed [tapa_pkg::CW-1:0]      r_z [tapa_pkg::CORDIC_STEPS+1];
    logic [tapa_pkg::ANGLE_W-1:0]        r_angle;

    logic [tapa_pkg::XNUM_W-1:0]         w_abs;
    logic [tapa_pkg::MAG_W-1:0]          w_yv;
    logic [tapa_pkg::LEN_W-1:0]          w_k;
    logic [tapa_pkg::MAG_W-1:0]          w_ms;
    logic [tapa_pkg::MAG_W-1:0]          w_ys;
    logic                                w_swap;
    logic signed [tapa_pkg::CW-1:0]      w_zf;
    logic [31:0]                         w_zc;
    logic [32:0]                         w_rnd;

    // magnitude of the cosine numerator, y = 4*h, common bit length
    assign w_abs = i_x_num[tapa_pkg::XNUM_W-1] ? -i_x_num : i_x_num;
    assign w_yv  = {i_h, 2'b00};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_x_num[tapa_pkg::XNUM_W-1];
            r_mag <= w_abs[tapa_pkg::MAG_W-1:0];
            r_yv  <= w_yv;
            r_len <= bit_len(w_abs[tapa_pkg::MAG_W-1:0] | w_yv);
        end
    end

    // scale both below 2^30, rotate by 90 degrees when the numerator is negative
    assign w_k    = (r_len > tapa_pkg::LEN_W'(tapa_pkg::NORM_BITS))
                  ? r_len - tapa_pkg::LEN_W'(tapa_pkg::NORM_BITS) : '0;
    assign w_ms   = r_mag >> w_k;
    assign w_ys   = r_yv >> w_k;
    assign w_swap = r_neg && (w_ms != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= w_swap ? w_ys[tapa_pkg::CW-1:0] : w_ms[tapa_pkg::CW-1:0];
            r_y[0] <= w_swap ? w_ms[tapa_pkg::CW-1:0] : w_ys[tapa_pkg::CW-1:0];
            r_z[0] <= w_swap ? tapa_pkg::DEG90 : '0;
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < tapa_pkg::CORDIC_STEPS; i++) begin : g_iter
        logic signed [tapa_pkg::CW-1:0] w_dx;
        logic signed [tapa_pkg::CW-1:0] w_dy;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + tapa_pkg::atan_deg(i);
                end else begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - tapa_pkg::atan_deg(i);
                end
            end
        end
    end

    // clamp to 0..180 degrees and round to the output fraction
    assign w_zf  = r_z[tapa_pkg::CORDIC_STEPS];
    assign w_zc  = (w_zf < 0) ? 32'd0
                 : (w_zf > tapa_pkg::DEG180) ? tapa_pkg::DEG180[31:0] : w_zf[31:0];
    assign w_rnd = (33'(w_zc) + 33'(tapa_pkg::ANG_HALF)) >> tapa_pkg::ANG_SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= w_rnd[tapa_pkg::ANGLE_W-1:0];
        end
    end

    assign o_angle = r_angle;

endmodule
